// File: sv/scs1a_pkg.sv
// Shared types, key codes and ASCII lookup tables for the set-1 scancode decoder.
`default_nettype none

package scs1a_pkg;

    localparam int ScanW = 8;
    localparam int CharW = 7;
    localparam int IdxW  = 6;

    localparam logic [ScanW-1:0] KeyPrefix = 8'he0;

    // make codes with the break bit stripped
    localparam logic [ScanW-2:0] KeyCtrl   = 7'h1d;
    localparam logic [ScanW-2:0] KeyShiftL = 7'h2a;
    localparam logic [ScanW-2:0] KeyShiftR = 7'h36;
    localparam logic [ScanW-2:0] KeyAlt    = 7'h38;
    localparam logic [ScanW-2:0] KeyCaps   = 7'h3a;
    localparam logic [ScanW-2:0] KeyEnd    = 7'h3b;

    typedef struct packed {
        logic prefix;
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } kbd_state_t;

    typedef struct packed {
        logic [CharW-1:0] char_code;
        logic             unknown_key;
        logic             shift_down;
        logic             ctrl_down;
        logic             alt_down;
        logic             caps_on;
    } key_result_t;

    function automatic logic [CharW-1:0] plain_char(input logic [IdxW-1:0] idx);
        logic [CharW-1:0] c;
        case (idx)
            6'h01: c = 7'h1b;
            6'h02: c = 7'h31;
            6'h03: c = 7'h32;
            6'h04: c = 7'h33;
            6'h05: c = 7'h34;
            6'h06: c = 7'h35;
            6'h07: c = 7'h36;
            6'h08: c = 7'h37;
            6'h09: c = 7'h38;
            6'h0a: c = 7'h39;
            6'h0b: c = 7'h30;
            6'h0c: c = 7'h2d;
            6'h0d: c = 7'h3d;
            6'h0e: c = 7'h08;
            6'h0f: c = 7'h09;
            6'h10: c = 7'h71;
            6'h11: c = 7'h77;
            6'h12: c = 7'h65;
            6'h13: c = 7'h72;
            6'h14: c = 7'h74;
            6'h15: c = 7'h79;
            6'h16: c = 7'h75;
            6'h17: c = 7'h69;
            6'h18: c = 7'h6f;
            6'h19: c = 7'h70;
            6'h1a: c = 7'h5b;
            6'h1b: c = 7'h5d;
            6'h1c: c = 7'h0d;
            6'h1e: c = 7'h61;
            6'h1f: c = 7'h73;
            6'h20: c = 7'h64;
            6'h21: c = 7'h66;
            6'h22: c = 7'h67;
            6'h23: c = 7'h68;
            6'h24: c = 7'h6a;
            6'h25: c = 7'h6b;
            6'h26: c = 7'h6c;
            6'h27: c = 7'h3b;
            6'h28: c = 7'h27;
            6'h29: c = 7'h60;
            6'h2b: c = 7'h5c;
            6'h2c: c = 7'h7a;
            6'h2d: c = 7'h78;
            6'h2e: c = 7'h63;
            6'h2f: c = 7'h76;
            6'h30: c = 7'h62;
            6'h31: c = 7'h6e;
            6'h32: c = 7'h6d;
            6'h33: c = 7'h2c;
            6'h34: c = 7'h2e;
            6'h35: c = 7'h2f;
            6'h37: c = 7'h2a;
            6'h39: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CharW-1:0] shift_char(input logic [IdxW-1:0] idx);
        logic [CharW-1:0] c;
        case (idx)
            6'h01: c = 7'h1b;
            6'h02: c = 7'h21;
            6'h03: c = 7'h40;
            6'h04: c = 7'h23;
            6'h05: c = 7'h24;
            6'h06: c = 7'h25;
            6'h07: c = 7'h5e;
            6'h08: c = 7'h26;
            6'h09: c = 7'h2a;
            6'h0a: c = 7'h28;
            6'h0b: c = 7'h29;
            6'h0c: c = 7'h5f;
            6'h0d: c = 7'h2b;
            6'h0e: c = 7'h08;
            6'h0f: c = 7'h09;
            6'h10: c = 7'h51;
            6'h11: c = 7'h57;
            6'h12: c = 7'h45;
            6'h13: c = 7'h52;
            6'h14: c = 7'h54;
            6'h15: c = 7'h59;
            6'h16: c = 7'h55;
            6'h17: c = 7'h49;
            6'h18: c = 7'h4f;
            6'h19: c = 7'h50;
            6'h1a: c = 7'h7b;
            6'h1b: c = 7'h7d;
            6'h1c: c = 7'h0d;
            6'h1e: c = 7'h41;
            6'h1f: c = 7'h53;
            6'h20: c = 7'h44;
            6'h21: c = 7'h46;
            6'h22: c = 7'h47;
            6'h23: c = 7'h48;
            6'h24: c = 7'h4a;
            6'h25: c = 7'h4b;
            6'h26: c = 7'h4c;
            6'h27: c = 7'h3a;
            6'h28: c = 7'h22;
            6'h29: c = 7'h7e;
            6'h2b: c = 7'h7c;
            6'h2c: c = 7'h5a;
            6'h2d: c = 7'h58;
            6'h2e: c = 7'h43;
            6'h2f: c = 7'h56;
            6'h30: c = 7'h42;
            6'h31: c = 7'h4e;
            6'h32: c = 7'h4d;
            6'h33: c = 7'h3c;
            6'h34: c = 7'h3e;
            6'h35: c = 7'h3f;
            6'h37: c = 7'h2a;
            6'h39: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/scancode_set1_to_ascii_unit.sv
// Top level of the set-1 scancode to ASCII decoder.
// Takes one keyboard byte per cycle unless stalled by a full result register, and
// delivers one result per make code through an input register, one table
// lookup plus modifier update, and a result register. Prefix bytes (0xE0) and
// break codes produce no result but still update the prefix and modifier
// state. Sustained rate is one byte per cycle, limited only by the result
// register being drained on the master side.
`default_nettype none

module scancode_set1_to_ascii_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
    output logic [4:0]      m_tuser    // [0] unknown_key, [1] shift_down, [2] ctrl_down,
                                       // [3] alt_down, [4] caps_on
);

    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic [scs1a_pkg::ScanW-1:0]       in_byte_reg;
    scs1a_pkg::kbd_state_t             state_reg;
    scs1a_pkg::kbd_state_t             state_next;
    logic                              has_result;
    scs1a_pkg::key_result_t            dec_res;
    scs1a_pkg::key_result_t            out_res;
    logic                              out_free;
    logic                              advance;
    logic                              load;

    scs1a_decode u_decode (
        .scan_byte  (in_byte_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .res        (dec_res)
    );

    assign advance  = in_valid_reg && (!has_result || out_free);
    assign load     = advance && has_result;
    assign s_tready = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    scs1a_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .load_res (dec_res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (out_res)
    );

    assign m_tdata = {1'b0, out_res.char_code};
    assign m_tuser = {out_res.caps_on, out_res.alt_down, out_res.ctrl_down,
                      out_res.shift_down, out_res.unknown_key};

    a_unknown_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'h00)
        else $error("unknown key carries a character");

    a_prefix_set: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_byte_reg == scs1a_pkg::KeyPrefix |=> state_reg.prefix)
        else $error("prefix flag not set after prefix byte");

    a_prefix_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_byte_reg != scs1a_pkg::KeyPrefix |=> !state_reg.prefix)
        else $error("prefix flag not cleared");

    a_caps_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && state_reg.caps != $past(state_reg.caps) |->
            $past(advance) && $past(in_byte_reg) == {1'b0, scs1a_pkg::KeyCaps} &&
            !$past(state_reg.prefix))
        else $error("caps lock changed without a caps make");

endmodule

`default_nettype wire

// File: sv/scs1a_decode.sv
// Combinational decode of one scancode byte against the current keyboard state.
`default_nettype none

module scs1a_decode (
    input  wire logic [scs1a_pkg::ScanW-1:0] scan_byte,
    input  wire scs1a_pkg::kbd_state_t      cur,
    output scs1a_pkg::kbd_state_t           nxt,
    output logic                            has_result,
    output scs1a_pkg::key_result_t          res
);

    logic                              ext;
    logic                              brk;
    logic [scs1a_pkg::ScanW-2:0]       mk;
    logic                              known;
    logic                              symbol;
    logic                              use_shift;
    logic [scs1a_pkg::CharW-1:0]       ch;

    assign ext = cur.prefix;
    assign brk = scan_byte[scs1a_pkg::ScanW-1];
    assign mk  = scan_byte[scs1a_pkg::ScanW-2:0];

    assign known = !brk && ((!ext && (mk != '0) && (mk < scs1a_pkg::KeyEnd)) ||
                            (ext && (mk == scs1a_pkg::KeyCtrl || mk == scs1a_pkg::KeyAlt)));

    assign symbol = !ext && ((mk < 7'h0e) || mk == 7'h29 || mk == 7'h1a || mk == 7'h1b ||
                             mk == 7'h2b || mk == 7'h27 || mk == 7'h28 || mk == 7'h33 ||
                             mk == 7'h34 || mk == 7'h35);

    assign use_shift = symbol ? cur.shift : (cur.shift ^ cur.caps);
    assign ch = use_shift ? scs1a_pkg::shift_char(mk[scs1a_pkg::IdxW-1:0])
                          : scs1a_pkg::plain_char(mk[scs1a_pkg::IdxW-1:0]);

    always_comb begin
        nxt        = cur;
        has_result = 1'b0;
        res.char_code   = '0;
        res.unknown_key = 1'b0;
        if (scan_byte == scs1a_pkg::KeyPrefix) begin
            nxt.prefix = 1'b1;
        end else begin
            nxt.prefix = 1'b0;
            if (brk) begin
                if (mk == scs1a_pkg::KeyCtrl) begin
                    nxt.ctrl = 1'b0;
                end else if (!ext && (mk == scs1a_pkg::KeyShiftL ||
                                      mk == scs1a_pkg::KeyShiftR)) begin
                    nxt.shift = 1'b0;
                end else if (mk == scs1a_pkg::KeyAlt) begin
                    nxt.alt = 1'b0;
                end
            end else begin
                has_result = 1'b1;
                if (known) begin
                    res.char_code = ch;
                    if (mk == scs1a_pkg::KeyCtrl) begin
                        nxt.ctrl = 1'b1;
                    end else if (!ext && (mk == scs1a_pkg::KeyShiftL ||
                                          mk == scs1a_pkg::KeyShiftR)) begin
                        nxt.shift = 1'b1;
                    end else if (mk == scs1a_pkg::KeyAlt) begin
                        nxt.alt = 1'b1;
                    end else if (!ext && mk == scs1a_pkg::KeyCaps) begin
                        nxt.caps = !cur.caps;
                    end
                end else begin
                    res.unknown_key = 1'b1;
                end
            end
        end
        res.shift_down = nxt.shift;
        res.ctrl_down  = nxt.ctrl;
        res.alt_down   = nxt.alt;
        res.caps_on    = nxt.caps;
    end

endmodule

`default_nettype wire

// File: sv/scs1a_out_stage.sv
// Result register on the master side of the decoder.
`default_nettype none

module scs1a_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire scs1a_pkg::key_result_t load_res,
    output logic                        free,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output scs1a_pkg::key_result_t      res
);

    logic                   valid_reg;
    logic                   valid_next;
    scs1a_pkg::key_result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign res      = res_reg;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for the set-1 scancode decoder: directed and random keystrokes in, decoded keys checked.
module testbench;

    localparam logic [7:0]  BreakBit    = 8'h80;
    localparam logic [15:0] PlainCtrl   = {9'h000, scs1a_pkg::KeyCtrl};
    localparam logic [15:0] PlainShiftL = {9'h000, scs1a_pkg::KeyShiftL};
    localparam logic [15:0] PlainShiftR = {9'h000, scs1a_pkg::KeyShiftR};
    localparam logic [15:0] PlainAlt    = {9'h000, scs1a_pkg::KeyAlt};
    localparam logic [15:0] PlainCaps   = {9'h000, scs1a_pkg::KeyCaps};
    localparam logic [15:0] PlainEnd    = {9'h000, scs1a_pkg::KeyEnd};
    localparam logic [15:0] ExtCtrl     = {scs1a_pkg::KeyPrefix, 1'b0, scs1a_pkg::KeyCtrl};
    localparam logic [15:0] ExtAlt      = {scs1a_pkg::KeyPrefix, 1'b0, scs1a_pkg::KeyAlt};
    localparam logic [15:0] SymbolEnd   = 16'h000e;

    localparam int RandomBytes   = 1000;
    localparam int QuietTail     = 150;
    localparam int HoldOffAt     = 400;
    localparam int HoldOffCycles = 300;
    localparam int DrainPoint    = 700;

    localparam logic [6:0] PlainChars [0:58] = '{
        7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
        7'h00, 7'h20, 7'h00
    };

    localparam logic [6:0] ShiftChars [0:58] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
        7'h00, 7'h20, 7'h00
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;

    logic [7:0]             pending_scan_bytes [$];
    scs1a_pkg::key_result_t expected_keys [$];
    scs1a_pkg::kbd_state_t  kbd = '0;

    logic rx_hold   = 1'b0;
    logic took_byte = 1'b0;
    int   bytes_taken   = 0;
    int   bytes_offered = 0;
    int   results_seen  = 0;
    int   error_count   = 0;
    int   send_gap      = 0;
    int   send_idle_pct = 0;
    int   send_ticks    = 0;
    int   rx_gap        = 0;
    int   rx_idle_pct   = 0;
    int   rx_ticks      = 0;

    scancode_set1_to_ascii_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("scancode_set1_to_ascii_unit test failed");
        $finish;
    end

    function automatic bit decode_scan_byte(input logic [7:0] scan,
                                            output scs1a_pkg::key_result_t key);
        logic [15:0] code;
        logic [15:0] stem;
        logic        shifted;
        key = '0;
        if (scan == scs1a_pkg::KeyPrefix) begin
            kbd.prefix = 1'b1;
            return 1'b0;
        end
        code = kbd.prefix ? {scs1a_pkg::KeyPrefix, scan} : {8'h00, scan};
        kbd.prefix = 1'b0;
        if (code[7]) begin
            stem = {code[15:8], 1'b0, code[6:0]};
            if (stem == PlainCtrl || stem == ExtCtrl) begin
                kbd.ctrl = 1'b0;
            end else if (stem == PlainShiftL || stem == PlainShiftR) begin
                kbd.shift = 1'b0;
            end else if (stem == PlainAlt || stem == ExtAlt) begin
                kbd.alt = 1'b0;
            end
            return 1'b0;
        end
        if ((code != 16'h0000 && code < PlainEnd) || code == ExtAlt || code == ExtCtrl) begin
            // digits and punctuation ignore caps lock
            if (code < SymbolEnd || code inside {16'h0029, 16'h001a, 16'h001b, 16'h002b,
                    16'h0027, 16'h0028, 16'h0033, 16'h0034, 16'h0035}) begin
                shifted = kbd.shift;
            end else begin
                shifted = kbd.shift ^ kbd.caps;
            end
            if (code < PlainEnd) begin
                key.char_code = shifted ? ShiftChars[code[5:0]] : PlainChars[code[5:0]];
            end
            if (code == PlainCtrl || code == ExtCtrl) begin
                kbd.ctrl = 1'b1;
            end else if (code == PlainShiftL || code == PlainShiftR) begin
                kbd.shift = 1'b1;
            end else if (code == PlainAlt || code == ExtAlt) begin
                kbd.alt = 1'b1;
            end else if (code == PlainCaps) begin
                kbd.caps = ~kbd.caps;
            end
        end else begin
            key.unknown_key = 1'b1;
        end
        key.shift_down = kbd.shift;
        key.ctrl_down  = kbd.ctrl;
        key.alt_down   = kbd.alt;
        key.caps_on    = kbd.caps;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    function automatic int urandom_pick();
        return $urandom_range(0, 2);
    endfunction

    function automatic int pick_idle_pct();
        case (urandom_pick())
            0: return 0;
            1: return 15;
            default: return 45;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        pending_scan_bytes.push_back(b);
    endtask

    task automatic push_tap(input logic [7:0] mk, input bit ext);
        if (ext) push_byte(scs1a_pkg::KeyPrefix);
        push_byte(mk);
        if (ext) push_byte(scs1a_pkg::KeyPrefix);
        push_byte(mk | BreakBit);
    endtask

    function automatic logic [7:0] any_table_key();
        return 8'($urandom_range(1, int'(scs1a_pkg::KeyEnd) - 1));
    endfunction

    // request side
    always @(negedge aclk) begin
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = s_tvalid;
        next_byte  = s_tdata;
        if (send_ticks % 97 == 0) send_idle_pct = pick_idle_pct();
        send_ticks++;
        if (aresetn && !(s_tvalid && !took_byte)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (bytes_offered == DrainPoint && expected_keys.size() != 0) begin
                // pause until the decoder has delivered everything
            end else if (pending_scan_bytes.size() != 0) begin
                if (pending_scan_bytes.size() >= QuietTail &&
                        $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 14);
                end else begin
                    next_byte  = pending_scan_bytes.pop_front();
                    next_valid = 1'b1;
                    bytes_offered++;
                end
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_byte;
    end

    // result side
    always @(negedge aclk) begin
        if (rx_ticks % 89 == 0) rx_idle_pct = pick_idle_pct();
        rx_ticks++;
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (pending_scan_bytes.size() >= QuietTail &&
                $urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        wait (bytes_taken >= HoldOffAt);
        @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        scs1a_pkg::key_result_t want;
        took_byte = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_keys.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_tdata, 0);
                end else begin
                    want = expected_keys.pop_front();
                    if (m_tdata[6:0] !== want.char_code)
                        report_mismatch("char_code", m_tdata[6:0], want.char_code);
                    if (m_tdata[7] !== 1'b0)
                        report_mismatch("tdata pad bit", m_tdata[7], 0);
                    if (m_tuser[0] !== want.unknown_key)
                        report_mismatch("unknown_key", m_tuser[0], want.unknown_key);
                    if (m_tuser[1] !== want.shift_down)
                        report_mismatch("shift_down", m_tuser[1], want.shift_down);
                    if (m_tuser[2] !== want.ctrl_down)
                        report_mismatch("ctrl_down", m_tuser[2], want.ctrl_down);
                    if (m_tuser[3] !== want.alt_down)
                        report_mismatch("alt_down", m_tuser[3], want.alt_down);
                    if (m_tuser[4] !== want.caps_on)
                        report_mismatch("caps_on", m_tuser[4], want.caps_on);
                end
            end
            if (s_tvalid && s_tready) begin
                took_byte = 1'b1;
                bytes_taken++;
                if (decode_scan_byte(s_tdata, want)) expected_keys.push_back(want);
            end
        end
    end

    initial begin
        logic [7:0] directed [];
        logic [7:0] mod_key;
        bit         ext;
        int         base;
        int         waited;

        directed = '{
            8'h00, 8'h7f, 8'hff, 8'h3b, 8'h2a, 8'h1e, 8'h02, 8'h3a, 8'h1e, 8'haa,
            8'h1e, 8'hba, 8'h3a, 8'he0, 8'he0, 8'h1d, 8'he0, 8'h2a, 8'he0, 8'h9d,
            8'he0, 8'h38, 8'he0, 8'hb8, 8'h1d, 8'h38, 8'h9d, 8'hb8
        };
        foreach (directed[i]) push_byte(directed[i]);
        base = pending_scan_bytes.size();
        while (pending_scan_bytes.size() - base < RandomBytes) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_tap(any_table_key(), 1'b0);
                4, 5: begin
                    mod_key = $urandom_range(0, 1) ? {1'b0, scs1a_pkg::KeyShiftL}
                                                   : {1'b0, scs1a_pkg::KeyShiftR};
                    push_byte(mod_key);
                    repeat ($urandom_range(1, 4)) push_tap(any_table_key(), 1'b0);
                    if ($urandom_range(0, 3) == 0)
                        mod_key = (mod_key == {1'b0, scs1a_pkg::KeyShiftL})
                                  ? {1'b0, scs1a_pkg::KeyShiftR}
                                  : {1'b0, scs1a_pkg::KeyShiftL};
                    push_byte(mod_key | BreakBit);
                end
                6: push_tap({1'b0, scs1a_pkg::KeyCaps}, 1'b0);
                7: begin
                    mod_key = $urandom_range(0, 1) ? {1'b0, scs1a_pkg::KeyCtrl}
                                                   : {1'b0, scs1a_pkg::KeyAlt};
                    ext     = 1'($urandom_range(0, 1));
                    if (ext) push_byte(scs1a_pkg::KeyPrefix);
                    push_byte(mod_key);
                    repeat ($urandom_range(1, 3)) push_tap(any_table_key(), 1'b0);
                    if (ext) push_byte(scs1a_pkg::KeyPrefix);
                    push_byte(mod_key | BreakBit);
                end
                8: begin
                    case ($urandom_range(0, 2))
                        0: push_tap(8'($urandom_range(int'(scs1a_pkg::KeyEnd), 127)), 1'b0);
                        1: push_tap(8'h00, 1'b0);
                        default: begin
                            push_byte(scs1a_pkg::KeyPrefix);
                            push_byte(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_scan_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        waited = 0;
        while (expected_keys.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (expected_keys.size() != 0)
            report_mismatch("results never delivered, count", expected_keys.size(), 0);
        if (error_count == 0) begin
            $display("scancode_set1_to_ascii_unit test passed");
        end else begin
            $display("scancode_set1_to_ascii_unit test failed");
        end
        $finish;
    end

endmodule
